>>> sv/assert_macros.svh
// Assertion macros shared by the alarm queue RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SATQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define SATQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> sv/satq_pkg.sv
// Package for the sorted alarm timer queue: widths, codes and cell types.
// No dependencies; used by satq_cell and the top level.
package satq_pkg;

  localparam int IdW        = 4;
  localparam int TmoW       = 32;
  localparam int ActW       = 2;
  localparam int IdSpace    = 16;
  localparam int NumAlarmsDef = 16;
  localparam logic [TmoW-1:0] StartTickReset = '0;

  localparam logic [ActW-1:0] ActTick   = 2'd0;
  localparam logic [ActW-1:0] ActSet    = 2'd1;
  localparam logic [ActW-1:0] ActCancel = 2'd2;

  localparam logic KindFired = 1'b0;
  localparam logic KindTick  = 1'b1;

  typedef enum logic [2:0] {
    OpHold,
    OpRemove,
    OpInsert,
    OpPop,
    OpClear
  } cell_op_e;

  typedef struct packed {
    logic            vld;
    logic [IdW-1:0]  id;
    logic [TmoW-1:0] tmo;
  } entry_t;

  typedef struct packed {
    cell_op_e        op;
    logic [IdW-1:0]  id;
    logic [TmoW-1:0] tmo;
  } cell_ctrl_t;

endpackage

>>> sv/sorted_alarm_timer_queue_unit.sv
// Top level of the sorted alarm timer queue: command decode, tick counter, result register.
// Depends on satq_pkg, satq_cell and assert_macros.svh.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  command  | start_i / busy_o    | action_i, alarm_id_i, timeout_i
//  result   | valid_o (strobe)    | kind_o, fired_id_o, tick_value_o, last_o
//  config   | cfg_we_i            | cfg_wdata_i (start tick, empties the queue)
//
// A cancel unlinks the alarm from the cell row at the transfer edge.
// A set unlinks at the transfer edge, then inserts from the StIns state in the row.
// A tick pops each due alarm from the head cell, one per cycle, as a fired result,
// then gives the tick-completed result; each result is registered and shown for one cycle.
// Reset empties the queue at once through the cell valid bits and loads tick zero.
// The receiver cannot stall, so results never wait.
module sorted_alarm_timer_queue_unit
  import satq_pkg::*;
#(
  parameter int NUM_ALARMS = NumAlarmsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic [ActW-1:0] action_i,
  input  logic [IdW-1:0]  alarm_id_i,
  input  logic [TmoW-1:0] timeout_i,
  input  logic            cfg_we_i,
  input  logic [TmoW-1:0] cfg_wdata_i,
  output logic            valid_o,
  output logic            kind_o,
  output logic [IdW-1:0]  fired_id_o,
  output logic [TmoW-1:0] tick_value_o,
  output logic            last_o
);

  `include "assert_macros.svh"

  localparam int NumCells = (NUM_ALARMS < IdSpace) ? NUM_ALARMS : IdSpace;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StIns  = 2'd1;
  localparam logic [1:0] StFire = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [TmoW-1:0] tick_q, tick_d;
  logic [IdW-1:0]  id_q, id_d;
  logic [TmoW-1:0] tmo_q, tmo_d;
  logic            valid_q, valid_d;
  logic            kind_q, kind_d;
  logic [IdW-1:0]  fid_q, fid_d;
  logic            last_q, last_d;

  cell_ctrl_t      ctrl;
  entry_t          ent [NumCells];
  logic [NumCells:0] rm;
  logic [NumCells:0] ins;
  logic [NumCells-1:0] vld_vec;
  logic            accept;
  logic            id_ok;

  assign busy_o = (state_q != StIdle);
  assign accept = start_i && !busy_o;
  assign id_ok  = (32'(alarm_id_i) < NUM_ALARMS);

  assign rm[0]  = 1'b0;
  assign ins[0] = 1'b0;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    entry_t left_e, right_e;
    if (i == 0) begin : g_first
      assign left_e = '0;
    end else begin : g_mid
      assign left_e = ent[i-1];
    end
    if (i == NumCells - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = ent[i+1];
    end
    satq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .left_i (left_e),
      .right_i(right_e),
      .rm_i   (rm[i]),
      .ins_i  (ins[i]),
      .ent_o  (ent[i]),
      .rm_o   (rm[i+1]),
      .ins_o  (ins[i+1])
    );
    assign vld_vec[i] = ent[i].vld;
  end

  always_comb begin
    state_d = state_q;
    tick_d  = tick_q;
    id_d    = id_q;
    tmo_d   = tmo_q;
    valid_d = 1'b0;
    kind_d  = kind_q;
    fid_d   = fid_q;
    last_d  = last_q;
    ctrl    = '{op: OpHold, id: alarm_id_i, tmo: timeout_i};
    if (cfg_we_i) begin
      ctrl.op = OpClear;
      tick_d  = cfg_wdata_i;
      state_d = StIdle;
    end else begin
      case (state_q)
        StIdle: begin
          if (accept) begin
            if (action_i == ActTick) begin
              tick_d  = tick_q + 1'b1;
              state_d = StFire;
            end else if ((action_i == ActSet || action_i == ActCancel) && id_ok) begin
              ctrl.op = OpRemove;
              if (action_i == ActSet && timeout_i != '0) begin
                id_d    = alarm_id_i;
                tmo_d   = timeout_i;
                state_d = StIns;
              end
            end
          end
        end
        StIns: begin
          ctrl.id  = id_q;
          ctrl.tmo = tmo_q;
          if (!ent[NumCells-1].vld) begin
            ctrl.op = OpInsert;
          end
          state_d = StIdle;
        end
        StFire: begin
          valid_d = 1'b1;
          if (ent[0].vld && (ent[0].tmo <= tick_q)) begin
            ctrl.op = OpPop;
            kind_d  = KindFired;
            fid_d   = ent[0].id;
            last_d  = 1'b0;
          end else begin
            kind_d  = KindTick;
            fid_d   = '0;
            last_d  = 1'b1;
            state_d = StIdle;
          end
        end
        default: state_d = StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tick_q  <= StartTickReset;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    tmo_q  <= tmo_d;
    kind_q <= kind_d;
    fid_q  <= fid_d;
    last_q <= last_d;
  end

  assign valid_o      = valid_q;
  assign kind_o       = kind_q;
  assign fired_id_o   = fid_q;
  assign tick_value_o = tick_q;
  assign last_o       = last_q;

  `SATQ_ASSERT(a_kind_last, clk_i, rst_ni, valid_o |-> (kind_o == last_o),
               "tick-completed flag and last flag disagree")
  `SATQ_ASSERT(a_contig, clk_i, rst_ni, $onehot({1'b0, vld_vec} + 1'b1),
               "queued alarms are not packed from the head cell")
  `SATQ_ASSERT(a_res_src, clk_i, rst_ni, valid_o |-> $past(state_q == StFire),
               "result strobe outside a tick run")
  `SATQ_ASSERT(a_tick_busy, clk_i, rst_ni,
               (accept && !cfg_we_i && action_i == ActTick) |=> busy_o,
               "tick transfer did not start a run")

endmodule

>>> sv/satq_cell.sv
// One cell of the sorted alarm chain: holds one queued alarm.
// Depends on satq_pkg; instantiated in a row by the top level.
module satq_cell
  import satq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     left_i,
  input  entry_t     right_i,
  input  logic       rm_i,
  input  logic       ins_i,
  output entry_t     ent_o,
  output logic       rm_o,
  output logic       ins_o
);

  logic            vld_q, vld_d;
  logic [IdW-1:0]  id_q, id_d;
  logic [TmoW-1:0] tmo_q, tmo_d;
  logic            ins_here;

  assign ent_o    = '{vld: vld_q, id: id_q, tmo: tmo_q};
  assign rm_o     = rm_i | (vld_q && (id_q == ctrl_i.id));
  assign ins_here = !vld_q || (tmo_q > ctrl_i.tmo);
  assign ins_o    = ins_here;

  always_comb begin
    vld_d = vld_q;
    id_d  = id_q;
    tmo_d = tmo_q;
    case (ctrl_i.op)
      OpRemove: begin
        if (rm_o) begin
          vld_d = right_i.vld;
          id_d  = right_i.id;
          tmo_d = right_i.tmo;
        end
      end
      OpPop: begin
        vld_d = right_i.vld;
        id_d  = right_i.id;
        tmo_d = right_i.tmo;
      end
      OpInsert: begin
        if (ins_here) begin
          if (ins_i) begin
            vld_d = left_i.vld;
            id_d  = left_i.id;
            tmo_d = left_i.tmo;
          end else begin
            vld_d = 1'b1;
            id_d  = ctrl_i.id;
            tmo_d = ctrl_i.tmo;
          end
        end
      end
      OpClear: vld_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    tmo_q <= tmo_d;
  end

endmodule
